// ===== hdl/tklmc_pkg.sv =====
// shared types and constants for the top-k longest mean coverage block
package tklmc_pkg;

  localparam int TOP_COUNT_DEF = 20;
  localparam int LEN_W         = 32;
  localparam int COV_W         = 32;
  localparam int KEPT_W        = 5;
  localparam int KEY_W         = LEN_W + COV_W;

  typedef struct packed {
    logic [LEN_W-1:0] seq_length;
    logic [COV_W-1:0] mean_coverage;
    logic             last_record;
  } in_req_t;

  typedef struct packed {
    logic [COV_W-1:0]  unique_coverage;
    logic [KEPT_W-1:0] kept_count;
    logic              empty_set;
  } out_req_t;

  // controller to datapath
  typedef struct packed {
    logic insert;
    logic step;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

// ===== hdl/tklmc_ctrl.sv =====
// controller state machine for the top-k longest mean coverage block
module tklmc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tklmc_pkg::dp_cmd_t cmd,
  input  tklmc_pkg::dp_stat_t stat
);
  import tklmc_pkg::*;

  typedef enum logic [0:0] {ST_IDLE, ST_DIV} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    cmd.insert   = in_valid && in_ready;
    cmd.step     = (state_r == ST_DIV) && !stat.div_done;
    cmd.load_out = (state_r == ST_DIV) && stat.div_done && (!out_valid_r || out_ready);

    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.insert && in_last) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cmd.load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result not presented after load");

  a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert && in_last) |=> (state_r == ST_DIV))
    else $error("last record did not start the divide");

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ready)
    else $error("request accepted while divider runs");

endmodule

// ===== hdl/tklmc_dpath.sv =====
// insertion cell chain, running sum and serial divider
module tklmc_dpath #(
  parameter int TOP_COUNT = tklmc_pkg::TOP_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tklmc_pkg::in_req_t  in_req,
  input  tklmc_pkg::dp_cmd_t  cmd,
  output tklmc_pkg::dp_stat_t stat,
  output tklmc_pkg::out_req_t out_req
);
  import tklmc_pkg::*;

  localparam int CNT_W = $clog2(TOP_COUNT + 1);
  localparam int SUM_W = COV_W + CNT_W;
  localparam int DC_W  = $clog2(SUM_W + 1);

  logic [KEY_W-1:0] ent_r   [TOP_COUNT];
  logic [KEY_W-1:0] ent_nxt [TOP_COUNT];
  logic [TOP_COUNT-1:0] gt;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] filled_r, filled_upd;
  logic [SUM_W-1:0] sum_r, sum_upd;
  logic             full, ins;

  // divider
  logic [SUM_W-1:0] quo_r;
  logic [CNT_W-1:0] rem_r, den_r, rem_nxt;
  logic [DC_W-1:0]  div_cnt_r;
  logic [CNT_W:0]   trial, diff;
  logic             ge;
  out_req_t         out_r;

  assign key  = {in_req.seq_length, in_req.mean_coverage};
  assign full = (filled_r == CNT_W'(TOP_COUNT));

  // each cell: new key wins over its entry, or entry is not yet filled
  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
    assign gt[i] = (CNT_W'(i) >= filled_r) || (key > ent_r[i]);
    if (i == 0) begin : g_head
      assign ent_nxt[i] = gt[i] ? key : ent_r[i];
    end else begin : g_body
      always_comb begin
        if (gt[i] && !gt[i-1]) begin
          ent_nxt[i] = key;
        end else if (gt[i]) begin
          ent_nxt[i] = ent_r[i-1];
        end else begin
          ent_nxt[i] = ent_r[i];
        end
      end
    end
  end

  // smallest entry drops out when a full table takes a new record
  assign ins = gt[TOP_COUNT-1];

  always_comb begin
    filled_upd = full ? filled_r : filled_r + 1'b1;
    sum_upd    = sum_r
               + (ins ? SUM_W'(in_req.mean_coverage) : '0)
               - ((ins && full) ? SUM_W'(ent_r[TOP_COUNT-1][COV_W-1:0]) : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      ent_r <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      sum_r    <= '0;
    end else if (cmd.insert) begin
      if (in_req.last_record) begin
        filled_r <= '0;
        sum_r    <= '0;
      end else begin
        filled_r <= filled_upd;
        sum_r    <= sum_upd;
      end
    end
  end

  // restoring division, one quotient bit per step
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && in_req.last_record) begin
      quo_r <= sum_upd;
      rem_r <= '0;
      den_r <= filled_upd;
    end else if (cmd.step) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= DC_W'(SUM_W);
    end else if (cmd.insert && in_req.last_record) begin
      div_cnt_r <= '0;
    end else if (cmd.step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  assign stat.div_done = (div_cnt_r == DC_W'(SUM_W));

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.unique_coverage <= (den_r == '0) ? '0 : quo_r[COV_W-1:0];
      out_r.kept_count      <= KEPT_W'(den_r);
      out_r.empty_set       <= (den_r == '0);
    end
  end

  assign out_req = out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(TOP_COUNT))
    else $error("fill count above table depth");

  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert && in_req.last_record) |=> !stat.div_done)
    else $error("divider did not restart on last record");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert && !in_req.last_record && !full) |=> (filled_r == $past(filled_r) + 1'b1))
    else $error("fill count did not advance on insert");

endmodule

// ===== hdl/top_k_longest_mean_coverage.sv =====
// top level of the top-k longest mean coverage block
//
// usage:
//   in channel carries one record per request (length, coverage, last flag).
//   records are ranked by length then coverage, both descending; the best
//   TOP_COUNT are kept in a chain of compare-insert cells. records that are
//   not marked last can stream at one per cycle while no result is being
//   computed.
//   the last record of a set is ranked too, then a restoring divider forms
//   the mean of the kept coverages, one quotient bit per cycle. with the
//   default depth the sum is 37 bits; the result request appears once all
//   quotient bits are formed and the output register is free.
//   in_ready is low for that stretch and rises again once the result sits in
//   the output register.
//   out channel carries the mean (integer, truncated), the kept count and an
//   empty flag. if the receiver stalls, the result holds in the output
//   register and new records are still taken; a second set's result waits
//   in the divider until the first is taken.
//   reset (rst_n low, synchronous) empties the table, clears the running
//   sum and drops any pending result.
module top_k_longest_mean_coverage #(
  parameter int TOP_COUNT = tklmc_pkg::TOP_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tklmc_pkg::in_req_t  in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output tklmc_pkg::out_req_t out_req
);
  import tklmc_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: accept control, divide sequencing, output valid
  tklmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_req.last_record),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: ranked table, running sum, divider, result register
  tklmc_dpath #(
    .TOP_COUNT (TOP_COUNT)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .stat    (stat),
    .out_req (out_req)
  );

endmodule
